FILE: hdl/maft_pkg.sv
// Shared types, constants and helper functions of the masked address filter table.
package maft_pkg;

    localparam int MAX_ENTRIES   = 1024;
    localparam int IDX_W         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int OCTETS        = 4;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 11;

    localparam logic [ADDR_W-1:0] FREE_MARK = 32'hffff_ffff;
    localparam logic [7:0]        OCTET_ALL = 8'hff;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CHECKED   = 3'd4
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] cmp;
        logic [OCTETS-1:0] mask;
    } t_entry;

    function automatic logic [ADDR_W-1:0] expand_mask(input logic [OCTETS-1:0] m);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int k = 0; k < OCTETS; k++) begin
            if (m[k]) begin
                r[8*k +: 8] = OCTET_ALL;
            end
        end
        return r;
    endfunction

    function automatic logic [OCTETS-1:0] derive_mask(input logic [ADDR_W-1:0] a);
        logic [OCTETS-1:0] m;
        m = '0;
        for (int k = 0; k < OCTETS; k++) begin
            m[k] = (a[8*k +: 8] != 8'd0);
        end
        return m;
    endfunction

endpackage

FILE: hdl/maft_cell.sv
// One cell of the entry ring: holds one filter entry and takes the entry on i_entry on a shift.
module maft_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  maft_pkg::t_entry i_entry,
    output maft_pkg::t_entry o_entry
);
    import maft_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: hdl/maft_ctrl.sv
// Request sequencer: steps the entry ring, edits the head entry and builds the result beat.
module maft_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [maft_pkg::REQ_W-1:0]           i_req_type,
    input  logic [maft_pkg::ADDR_W-1:0]          i_address,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,
    input  maft_pkg::t_entry                     i_head,
    input  maft_pkg::t_entry                     i_next,
    output maft_pkg::t_entry                     o_emit,
    output logic                                 o_shift,
    output logic                                 o_busy,
    output logic                                 o_valid,
    output logic [maft_pkg::STATUS_W-1:0]        o_status,
    output logic                                 o_drop,
    output logic [maft_pkg::ENTRY_COUNT_W-1:0]   o_entry_count
);
    import maft_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state             r_state;
    logic [REQ_W-1:0]   r_req;
    logic [ADDR_W-1:0]  r_addr;
    logic [OCTETS-1:0]  r_mask;
    logic [IDX_W-1:0]   r_step;
    logic               r_found;
    logic [CNT_W-1:0]   r_used;
    logic               r_ban;
    logic               r_busy;
    logic               r_valid;
    logic [STATUS_W-1:0] r_status;
    logic               r_drop;
    logic [ENTRY_COUNT_W-1:0] r_count;

    logic               n_found;
    logic [CNT_W-1:0]   n_used;
    logic [STATUS_W-1:0] n_status;
    logic               n_drop;
    logic [CNT_W-1:0]   step_ext;
    logic               in_use;
    logic               at_tail;
    logic               last_step;
    logic               event_now;
    t_entry             new_entry;

    assign step_ext  = CNT_W'(r_step);
    assign in_use    = step_ext < r_used;
    assign at_tail   = step_ext == r_used;
    assign last_step = r_step == IDX_W'(MAX_ENTRIES - 1);
    assign new_entry = '{cmp: r_addr, mask: r_mask};

    always_comb begin
        o_emit    = i_head;
        n_used    = r_used;
        event_now = 1'b0;
        n_status  = ST_CHECKED;
        n_drop    = 1'b0;
        unique case (r_req)
            REQ_ADD: begin
                if (!r_found && in_use && i_head.cmp == FREE_MARK) begin
                    event_now = 1'b1;
                    o_emit    = new_entry;
                end else if (!r_found && at_tail) begin
                    event_now = 1'b1;
                    o_emit    = new_entry;
                    n_used    = r_used + 1'b1;
                end
                n_status = (r_found || event_now) ? ST_ADDED : ST_FULL;
            end
            REQ_REMOVE: begin
                if (!r_found && in_use && i_head.cmp == r_addr && i_head.mask == r_mask) begin
                    event_now = 1'b1;
                    n_used    = r_used - 1'b1;
                end
                if (r_found || event_now) begin
                    o_emit = i_next;
                end
                n_status = (r_found || event_now) ? ST_REMOVED : ST_NOT_FOUND;
            end
            default: begin
                if (!r_found && in_use &&
                    (r_addr & expand_mask(i_head.mask)) == i_head.cmp) begin
                    event_now = 1'b1;
                end
                n_status = ST_CHECKED;
                n_drop   = (r_found || event_now) ? r_ban : ~r_ban;
            end
        endcase
        n_found = r_found | event_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_used  <= '0;
            r_ban   <= 1'b1;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_ban <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req_type;
                        r_addr  <= i_address;
                        r_mask  <= derive_mask(i_address);
                        r_step  <= '0;
                        r_found <= 1'b0;
                        r_busy  <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_step  <= r_step + 1'b1;
                    r_found <= n_found;
                    r_used  <= n_used;
                    if (last_step) begin
                        r_busy   <= 1'b0;
                        r_valid  <= 1'b1;
                        r_status <= n_status;
                        r_drop   <= n_drop;
                        r_count  <= ENTRY_COUNT_W'(n_used);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_shift       = r_busy;
    assign o_busy        = r_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_drop        = r_drop;
    assign o_entry_count = r_count;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("accepted request did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $fell(r_busy))
        else $error("result beat without end of scan");

    a_no_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_valid)
        else $error("result beat during scan");

    a_drop_check_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_CHECKED) |-> !r_drop)
        else $error("drop set on an edit result");
`endif

endmodule

FILE: hdl/masked_address_filter_table.sv
// Top level of the masked address filter table: ring of entry cells and the request sequencer.
//
// A request is taken when start is high and busy is low. The filter entries sit in a ring of
// MAX_ENTRIES cells that rotates by one entry per clock while a request is in work, so every
// request of any type makes one full turn of the ring before its result beat. The result beat
// is on o_status, o_drop and o_entry_count for exactly one cycle with o_valid high; the
// receiver cannot stall it. busy drops in that same cycle, so the next request may start while
// the result is shown. The user must write the ban_mode register through i_cfg_we /
// i_cfg_wdata only while no request is in work; the block itself does not enforce this.
// Entries read as undefined until added, and only entries in use are ever looked at.
module masked_address_filter_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [maft_pkg::REQ_W-1:0]          i_req_type,
    input  logic [maft_pkg::ADDR_W-1:0]         i_address,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    output logic                                o_valid,
    output logic [maft_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_drop,
    output logic [maft_pkg::ENTRY_COUNT_W-1:0]  o_entry_count
);
    import maft_pkg::*;

    localparam int NEXT_IDX = (MAX_ENTRIES > 1) ? 1 : 0;

    t_entry w_cell [MAX_ENTRIES];
    t_entry w_emit;
    logic   w_shift;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        if (k == MAX_ENTRIES - 1) begin : g_tail
            maft_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_emit),
                .o_entry (w_cell[k])
            );
        end else begin : g_body
            maft_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

    maft_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_head        (w_cell[0]),
        .i_next        (w_cell[NEXT_IDX]),
        .o_emit        (w_emit),
        .o_shift       (w_shift),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_drop        (o_drop),
        .o_entry_count (o_entry_count)
    );

endmodule
